[rtl/dserf_pkg.sv]
package dserf_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS    = 3'd0,
        CFG_WIDTH     = 3'd1,
        CFG_HEIGHT    = 3'd2,
        CFG_NODATA    = 3'd3,
        CFG_NODATA_EN = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        logic [4:0]                 erosion_radius;
        logic [10:0]                raster_width;
        logic [15:0]                raster_height;
        logic signed [SAMPLE_W-1:0] nodata_value;
        logic                       nodata_enable;
    } cfg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DECIDE,
        F_WRITE,
        F_FLUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_LAST
    } back_state_t;

    function automatic int unsigned eff_radius(input logic [4:0] r, input int unsigned maxr);
        if (r == 5'd0)
        begin
            return 1;
        end
        if (32'(r) > maxr)
        begin
            return maxr;
        end
        return 32'(r);
    endfunction

    function automatic int unsigned eff_width(input logic [10:0] w, input int unsigned maxc);
        if (w == 11'd0)
        begin
            return 1;
        end
        if (32'(w) > maxc)
        begin
            return maxc;
        end
        return 32'(w);
    endfunction

    function automatic logic [15:0] eff_height(input logic [15:0] h);
        return (h == 16'd0) ? 16'd1 : h;
    endfunction

    function automatic logic is_background(input logic signed [SAMPLE_W-1:0] v, input cfg_t c);
        return (v == '0) || (c.nodata_enable && (v == c.nodata_value));
    endfunction

endpackage

[rtl/dserf_in_if.sv]
interface dserf_in_if;
    import dserf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic                       cmd;
    logic signed [SAMPLE_W-1:0] pixel_value;
    modport source (output valid, output cmd, output pixel_value, input ready);
    modport sink (input valid, input cmd, input pixel_value, output ready);
endinterface

[rtl/dserf_out_if.sv]
interface dserf_out_if;
    import dserf_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_value;
    logic                       frame_last;
    modport source (output valid, output out_value, output frame_last, input ready);
    modport sink (input valid, input out_value, input frame_last, output ready);
endinterface

[rtl/dserf_ram.sv]
module dserf_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

[rtl/dserf_queue.sv]
module dserf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop && valid)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
        end
    end
endmodule

[rtl/dserf_front.sv]
module dserf_front
    import dserf_pkg::*;
#(
    parameter int MAX_RADIUS = 16,
    parameter int MAX_COLS = 1024,
    localparam int FLAG_ROWS = 2 * MAX_RADIUS + 1,
    localparam int FLAG_DEPTH = FLAG_ROWS * MAX_COLS,
    localparam int DELAY_DEPTH = MAX_RADIUS * MAX_COLS + MAX_RADIUS,
    localparam int COL_W = $clog2(MAX_COLS),
    localparam int WID_W = $clog2(MAX_COLS + 1),
    localparam int RAD_W = $clog2(MAX_RADIUS + 1),
    localparam int FA_W = $clog2(FLAG_DEPTH),
    localparam int DA_W = $clog2(DELAY_DEPTH),
    localparam int DLY_W = $clog2(DELAY_DEPTH + 1),
    localparam int FR_W = $clog2(FLAG_ROWS)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       restart,
    dserf_in_if.sink                   pix_in,
    output logic                       flag_we,
    output logic [FA_W-1:0]            flag_waddr,
    output logic                       flag_wdata,
    output logic                       dly_we,
    output logic [DA_W-1:0]            dly_waddr,
    output logic [SAMPLE_W-1:0]        dly_wdata,
    output logic                       dly_re,
    output logic [DA_W-1:0]            dly_raddr,
    input  logic [SAMPLE_W-1:0]        dly_rdata,
    output logic                       q_push,
    output logic signed [SAMPLE_W-1:0] q_value,
    output logic [15:0]                q_row,
    output logic [COL_W-1:0]           q_col,
    output logic [FR_W-1:0]            q_frow,
    input  logic                       q_full,
    input  logic                       q_empty,
    input  logic                       back_busy
);
    front_state_t               state_reg, state_next;
    logic                       cmd_reg;
    logic signed [SAMPLE_W-1:0] val_reg;
    logic                       fire_reg, fire_next;
    logic [DLY_W-1:0]           delay_reg;
    logic [15:0]                in_row_reg, in_row_next;
    logic [COL_W-1:0]           in_col_reg, in_col_next;
    logic [FA_W-1:0]            in_base_reg, in_base_next;
    logic [DA_W-1:0]            in_ptr_reg, in_ptr_next;
    logic [DLY_W-1:0]           fcnt_reg, fcnt_next;
    logic [15:0]                out_row_reg, out_row_next;
    logic [COL_W-1:0]           out_col_reg, out_col_next;
    logic [FR_W-1:0]            out_frow_reg, out_frow_next;
    logic [DA_W-1:0]            out_ptr_reg, out_ptr_next;
    logic [RAD_W-1:0]           eff_r;
    logic [WID_W-1:0]           eff_w;
    logic [15:0]                eff_h;
    logic                       in_col_last, out_col_last;

    assign eff_r = RAD_W'(eff_radius(cfg.erosion_radius, MAX_RADIUS));
    assign eff_w = WID_W'(eff_width(cfg.raster_width, MAX_COLS));
    assign eff_h = eff_height(cfg.raster_height);
    assign in_col_last  = (WID_W'(in_col_reg) + WID_W'(1) >= eff_w);
    assign out_col_last = (WID_W'(out_col_reg) + WID_W'(1) >= eff_w);

    assign pix_in.ready = (state_reg == F_IDLE) && q_empty && !back_busy;

    assign flag_waddr = in_base_reg + FA_W'(in_col_reg);
    assign flag_wdata = is_background(val_reg, cfg);
    assign dly_waddr  = in_ptr_reg;
    assign dly_wdata  = val_reg;
    assign dly_raddr  = out_ptr_reg;
    assign q_value    = dly_rdata;
    assign q_row      = out_row_reg;
    assign q_col      = out_col_reg;
    assign q_frow     = out_frow_reg;

    always_ff @(posedge clk)
    begin
        if (pix_in.valid && pix_in.ready)
        begin
            cmd_reg <= pix_in.cmd;
            val_reg <= pix_in.pixel_value;
        end
        delay_reg <= DLY_W'(32'(eff_r) * 32'(eff_w) + 32'(eff_r));
        fire_reg  <= fire_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            in_base_reg  <= '0;
            in_ptr_reg   <= '0;
            fcnt_reg     <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_frow_reg <= '0;
            out_ptr_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            in_row_reg   <= in_row_next;
            in_col_reg   <= in_col_next;
            in_base_reg  <= in_base_next;
            in_ptr_reg   <= in_ptr_next;
            fcnt_reg     <= fcnt_next;
            out_row_reg  <= out_row_next;
            out_col_reg  <= out_col_next;
            out_frow_reg <= out_frow_next;
            out_ptr_reg  <= out_ptr_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        fire_next     = fire_reg;
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_base_next  = in_base_reg;
        in_ptr_next   = in_ptr_reg;
        fcnt_next     = fcnt_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_frow_next = out_frow_reg;
        out_ptr_next  = out_ptr_reg;
        flag_we       = 1'b0;
        dly_we        = 1'b0;
        dly_re        = 1'b0;
        q_push        = 1'b0;

        case (state_reg)
            F_IDLE:
            begin
                if (pix_in.valid && pix_in.ready)
                begin
                    state_next = F_DECIDE;
                end
            end
            F_DECIDE:
            begin
                if (cmd_reg)
                begin
                    if ((in_row_reg < eff_h) || (out_row_reg >= eff_h))
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        dly_re     = 1'b1;
                        state_next = F_FLUSH;
                    end
                end
                else if (in_row_reg >= eff_h)
                begin
                    if (out_row_reg < eff_h)
                    begin
                        state_next = F_IDLE;
                    end
                    else
                    begin
                        in_row_next   = '0;
                        in_col_next   = '0;
                        in_base_next  = '0;
                        in_ptr_next   = '0;
                        fcnt_next     = '0;
                        out_row_next  = '0;
                        out_col_next  = '0;
                        out_frow_next = '0;
                        out_ptr_next  = '0;
                    end
                end
                else
                begin
                    fire_next  = (fcnt_reg >= delay_reg);
                    dly_re     = fire_next;
                    state_next = F_WRITE;
                end
            end
            F_WRITE:
            begin
                flag_we = 1'b1;
                dly_we  = 1'b1;
                in_ptr_next = (in_ptr_reg == DA_W'(DELAY_DEPTH - 1)) ? '0 : in_ptr_reg + 1'b1;
                if (fcnt_reg < delay_reg)
                begin
                    fcnt_next = fcnt_reg + 1'b1;
                end
                if (in_col_last)
                begin
                    in_col_next  = '0;
                    in_row_next  = in_row_reg + 16'd1;
                    in_base_next = (in_base_reg == FA_W'(FLAG_DEPTH - MAX_COLS)) ? '0
                                   : in_base_reg + FA_W'(MAX_COLS);
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                q_push = fire_reg;
                state_next = F_IDLE;
            end
            F_FLUSH:
            begin
                if (!q_full)
                begin
                    q_push     = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase

        if (q_push)
        begin
            out_ptr_next = (out_ptr_reg == DA_W'(DELAY_DEPTH - 1)) ? '0 : out_ptr_reg + 1'b1;
            if (out_col_last)
            begin
                out_col_next  = '0;
                out_row_next  = out_row_reg + 16'd1;
                out_frow_next = (out_frow_reg == FR_W'(FLAG_ROWS - 1)) ? '0
                                : out_frow_reg + 1'b1;
            end
            else
            begin
                out_col_next = out_col_reg + 1'b1;
            end
        end

        if (restart)
        begin
            in_row_next   = '0;
            in_col_next   = '0;
            in_base_next  = '0;
            in_ptr_next   = '0;
            fcnt_next     = '0;
            out_row_next  = '0;
            out_col_next  = '0;
            out_frow_next = '0;
            out_ptr_next  = '0;
        end
    end
endmodule

[rtl/dserf_back.sv]
module dserf_back
    import dserf_pkg::*;
#(
    parameter int MAX_RADIUS = 16,
    parameter int MAX_COLS = 1024,
    localparam int FLAG_ROWS = 2 * MAX_RADIUS + 1,
    localparam int FLAG_DEPTH = FLAG_ROWS * MAX_COLS,
    localparam int COL_W = $clog2(MAX_COLS),
    localparam int WID_W = $clog2(MAX_COLS + 1),
    localparam int RAD_W = $clog2(MAX_RADIUS + 1),
    localparam int FA_W = $clog2(FLAG_DEPTH),
    localparam int FR_W = $clog2(FLAG_ROWS),
    localparam int SW = RAD_W + 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cfg_t                       cfg,
    input  logic                       q_valid,
    input  logic signed [SAMPLE_W-1:0] q_value,
    input  logic [15:0]                q_row,
    input  logic [COL_W-1:0]           q_col,
    input  logic [FR_W-1:0]            q_frow,
    output logic                       q_pop,
    output logic                       flag_re,
    output logic [FA_W-1:0]            flag_raddr,
    input  logic                       flag_rdata,
    output logic                       busy,
    dserf_out_if.source                pix_out
);
    back_state_t                state_reg, state_next;
    logic signed [SAMPLE_W-1:0] val_reg;
    logic                       last_reg;
    logic [RAD_W:0]             ix_reg, iy_reg;
    logic [FA_W-1:0]            base_reg;
    logic [COL_W-1:0]           scol_reg;
    logic [COL_W-1:0]           col0_reg;
    logic                       erode_reg;
    logic                       chk_reg;
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_val_reg;
    logic                       out_last_reg;

    logic [RAD_W-1:0]           eff_r;
    logic [WID_W-1:0]           eff_w;
    logic [15:0]                eff_h;
    logic [31:0]                r32, w32, h32, hr32, hc32, t32;
    logic                       head_edge, head_last;
    logic [RAD_W:0]             two_r;
    logic signed [SW-1:0]       dx_s, dy_s;
    logic signed [2*SW-1:0]     dx_w, dy_w;
    logic [2*SW:0]              dist_sq, rad_sq;
    logic                       in_disk, erode_now;

    assign eff_r = RAD_W'(eff_radius(cfg.erosion_radius, MAX_RADIUS));
    assign eff_w = WID_W'(eff_width(cfg.raster_width, MAX_COLS));
    assign eff_h = eff_height(cfg.raster_height);
    assign r32   = 32'(eff_r);
    assign w32   = 32'(eff_w);
    assign h32   = 32'(eff_h);
    assign hr32  = 32'(q_row);
    assign hc32  = 32'(q_col);
    assign two_r = (RAD_W + 1)'({eff_r, 1'b0});

    assign head_edge = (hc32 < r32) || (hc32 + r32 >= w32) || (hr32 < r32)
                       || (hr32 + r32 >= h32);
    assign head_last = (hr32 + 32'd1 == h32) && (hc32 + 32'd1 == w32);

    always_comb
    begin
        t32 = 32'(q_frow) + 32'(FLAG_ROWS) - r32;
        if (t32 >= 32'(FLAG_ROWS))
        begin
            t32 = t32 - 32'(FLAG_ROWS);
        end
    end

    assign dx_s    = $signed({1'b0, ix_reg}) - $signed({2'b00, eff_r});
    assign dy_s    = $signed({1'b0, iy_reg}) - $signed({2'b00, eff_r});
    assign dx_w    = dx_s;
    assign dy_w    = dy_s;
    assign dist_sq = (2 * SW + 1)'($unsigned(dx_w * dx_w)) + (2 * SW + 1)'($unsigned(dy_w * dy_w));
    assign rad_sq  = (2 * SW + 1)'(eff_r) * (2 * SW + 1)'(eff_r);
    assign in_disk = (dist_sq <= rad_sq);
    assign erode_now = erode_reg || (chk_reg && flag_rdata);

    assign q_pop      = (state_reg == B_IDLE) && q_valid && !out_valid_reg;
    assign flag_re    = (state_reg == B_SCAN);
    assign flag_raddr = base_reg + FA_W'(scol_reg);
    assign busy       = (state_reg != B_IDLE);

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_value  = out_val_reg;
    assign pix_out.frame_last = out_last_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_pop && !is_background(q_value, cfg) && !head_edge)
                begin
                    state_next = B_SCAN;
                end
            end
            B_SCAN:
            begin
                if ((ix_reg == two_r) && (iy_reg == two_r))
                begin
                    state_next = B_LAST;
                end
            end
            B_LAST:
            begin
                state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                if (q_pop)
                begin
                    val_reg   <= q_value;
                    last_reg  <= head_last;
                    ix_reg    <= '0;
                    iy_reg    <= '0;
                    base_reg  <= FA_W'(t32 * 32'(MAX_COLS));
                    scol_reg  <= COL_W'(hc32 - r32);
                    col0_reg  <= COL_W'(hc32 - r32);
                    erode_reg <= 1'b0;
                    chk_reg   <= 1'b0;
                    out_last_reg <= head_last;
                    out_val_reg  <= (is_background(q_value, cfg)) ? q_value
                                    : (head_edge ? '0 : q_value);
                end
            end
            B_SCAN:
            begin
                erode_reg <= erode_now;
                chk_reg   <= in_disk;
                if (ix_reg == two_r)
                begin
                    ix_reg   <= '0;
                    iy_reg   <= iy_reg + 1'b1;
                    scol_reg <= col0_reg;
                    base_reg <= (base_reg == FA_W'(FLAG_DEPTH - MAX_COLS)) ? '0
                                : base_reg + FA_W'(MAX_COLS);
                end
                else
                begin
                    ix_reg   <= ix_reg + 1'b1;
                    scol_reg <= scol_reg + 1'b1;
                end
            end
            B_LAST:
            begin
                out_val_reg  <= erode_now ? '0 : val_reg;
                out_last_reg <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pix_out.valid && pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if ((q_pop && (state_next == B_IDLE)) || (state_reg == B_LAST))
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end
endmodule

[rtl/disk_erosion_raster_filter.sv]
// Channel   Dir  Payload                      Accept
// pix_in    in   cmd, pixel_value             valid & ready
// pix_out   out  out_value, frame_last        valid & ready
// cfg       in   cfg_index, cfg_data          cfg_we
//
// A pixel passes F_IDLE, F_DECIDE and F_WRITE in the front, F_DECIDE twice when it
// restarts a finished frame, and a flush beat passes F_FLUSH in place of F_WRITE; a
// queued pixel that needs the disk test then scans (2*R+1)^2 cells in B_SCAN, one flag
// line-store read each, then B_LAST. Edge, zero and nodata pixels skip the scan.
// Reset clears control state only; line stores need no clearing pass.
// A stalled output holds its beat; the front queues one more beat, then holds ready low.
module disk_erosion_raster_filter
    import dserf_pkg::*;
#(
    parameter int MAX_RADIUS = 16,
    parameter int MAX_COLS = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dserf_in_if.sink              pix_in,
    dserf_out_if.source           pix_out
);
    localparam int FLAG_ROWS = 2 * MAX_RADIUS + 1;
    localparam int FLAG_DEPTH = FLAG_ROWS * MAX_COLS;
    localparam int DELAY_DEPTH = MAX_RADIUS * MAX_COLS + MAX_RADIUS;
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int FA_W = $clog2(FLAG_DEPTH);
    localparam int DA_W = $clog2(DELAY_DEPTH);
    localparam int FR_W = $clog2(FLAG_ROWS);
    localparam int ENT_W = SAMPLE_W + 16 + COL_W + FR_W;

    cfg_t                       cfg_reg;
    logic                       restart;
    logic                       flag_we, flag_wdata, flag_re, flag_rdata;
    logic [FA_W-1:0]            flag_waddr, flag_raddr;
    logic                       dly_we, dly_re;
    logic [DA_W-1:0]            dly_waddr, dly_raddr;
    logic [SAMPLE_W-1:0]        dly_wdata, dly_rdata;
    logic                       q_push, q_full, q_valid, q_pop, back_busy;
    logic signed [SAMPLE_W-1:0] f_value, b_value;
    logic [15:0]                f_row, b_row;
    logic [COL_W-1:0]           f_col, b_col;
    logic [FR_W-1:0]            f_frow, b_frow;
    logic [ENT_W-1:0]           q_in, q_out;

    assign restart = cfg_we && ((cfg_index == CFG_RADIUS) || (cfg_index == CFG_WIDTH)
                     || (cfg_index == CFG_HEIGHT) || (cfg_index == CFG_NODATA)
                     || (cfg_index == CFG_NODATA_EN));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.erosion_radius <= 5'd1;
            cfg_reg.raster_width   <= 11'd1024;
            cfg_reg.raster_height  <= 16'd1;
            cfg_reg.nodata_value   <= '0;
            cfg_reg.nodata_enable  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RADIUS:    cfg_reg.erosion_radius <= cfg_data[4:0];
                CFG_WIDTH:     cfg_reg.raster_width   <= cfg_data[10:0];
                CFG_HEIGHT:    cfg_reg.raster_height  <= cfg_data[15:0];
                CFG_NODATA:    cfg_reg.nodata_value   <= cfg_data[SAMPLE_W-1:0];
                CFG_NODATA_EN: cfg_reg.nodata_enable  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    dserf_front #(.MAX_RADIUS(MAX_RADIUS), .MAX_COLS(MAX_COLS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .restart    (restart),
        .pix_in     (pix_in),
        .flag_we    (flag_we),
        .flag_waddr (flag_waddr),
        .flag_wdata (flag_wdata),
        .dly_we     (dly_we),
        .dly_waddr  (dly_waddr),
        .dly_wdata  (dly_wdata),
        .dly_re     (dly_re),
        .dly_raddr  (dly_raddr),
        .dly_rdata  (dly_rdata),
        .q_push     (q_push),
        .q_value    (f_value),
        .q_row      (f_row),
        .q_col      (f_col),
        .q_frow     (f_frow),
        .q_full     (q_full),
        .q_empty    (!q_valid),
        .back_busy  (back_busy)
    );

    dserf_ram #(.WIDTH(1), .DEPTH(FLAG_DEPTH)) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .re    (flag_re),
        .raddr (flag_raddr),
        .rdata (flag_rdata)
    );

    dserf_ram #(.WIDTH(SAMPLE_W), .DEPTH(DELAY_DEPTH)) u_delay_ram (
        .clk   (clk),
        .we    (dly_we),
        .waddr (dly_waddr),
        .wdata (dly_wdata),
        .re    (dly_re),
        .raddr (dly_raddr),
        .rdata (dly_rdata)
    );

    assign q_in = {f_value, f_row, f_col, f_frow};
    assign {b_value, b_row, b_col, b_frow} = q_out;

    dserf_queue #(.WIDTH(ENT_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    dserf_back #(.MAX_RADIUS(MAX_RADIUS), .MAX_COLS(MAX_COLS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_valid    (q_valid),
        .q_value    (b_value),
        .q_row      (b_row),
        .q_col      (b_col),
        .q_frow     (b_frow),
        .q_pop      (q_pop),
        .flag_re    (flag_re),
        .flag_raddr (flag_raddr),
        .flag_rdata (flag_rdata),
        .busy       (back_busy),
        .pix_out    (pix_out)
    );
endmodule

[tb/sv/disk_erosion_raster_filter_test.sv]
`timescale 1ns / 100ps

module disk_erosion_raster_filter_test;
    import dserf_pkg::*;

    localparam int RAD_MAX = 16;
    localparam int COLS_MAX = 1024;
    localparam int FLAG_ROWS = 2 * RAD_MAX + 1;
    localparam int DELAY_DEPTH = RAD_MAX * COLS_MAX + RAD_MAX;
    localparam int SETTLE_CYCLES = 1200;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEM_GOAL = 850;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam bit CMD_PIXEL = 1'b0;
    localparam bit CMD_FLUSH = 1'b1;

    typedef enum logic {ROW_PIX, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  idx;
        bit                    cmd;
        logic [31:0]           data;
        bit                    typed;
        logic [31:0]           exp_value;
        bit                    exp_last;
    } dir_row_t;

    typedef struct {
        logic [31:0] value;
        bit          last;
    } pix_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dserf_in_if pin ();
    dserf_out_if pout ();

    disk_erosion_raster_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pin),
        .pix_out   (pout)
    );

    bit          bg_flags [FLAG_ROWS*COLS_MAX];
    logic [31:0] value_line [DELAY_DEPTH];
    int unsigned in_row, in_col, out_row, out_col;
    logic [4:0]  m_radius;
    logic [10:0] m_width;
    logic [15:0] m_height;
    logic [31:0] m_nodata;
    bit          m_nodata_en;

    pix_result_t pending_pixels[$];
    int errors = 0;
    int items = 0;
    int stall_count = 0;
    bit calm = 0;
    bit hold_req = 0;

    function automatic int unsigned radius_now();
        if (m_radius == 0)
        begin
            return 1;
        end
        return (m_radius > RAD_MAX) ? RAD_MAX : m_radius;
    endfunction

    function automatic int unsigned width_now();
        if (m_width == 0)
        begin
            return 1;
        end
        return (m_width > COLS_MAX) ? COLS_MAX : m_width;
    endfunction

    function automatic int unsigned height_now();
        return (m_height == 0) ? 1 : m_height;
    endfunction

    function automatic bit is_background(logic [31:0] v);
        return (v == 0) || (m_nodata_en && v == m_nodata);
    endfunction

    function automatic void restart_counts();
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic void apply_config(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        case (idx)
            CFG_RADIUS:    m_radius = d[4:0];
            CFG_WIDTH:     m_width = d[10:0];
            CFG_HEIGHT:    m_height = d[15:0];
            CFG_NODATA:    m_nodata = d;
            CFG_NODATA_EN: m_nodata_en = d[0];
            default:       return;
        endcase
        restart_counts();
    endfunction

    function automatic pix_result_t erode_pixel(logic [31:0] v);
        pix_result_t res;
        int r, c, rad, w, h, fr;
        bit zap;
        r = out_row;
        c = out_col;
        rad = radius_now();
        w = width_now();
        h = height_now();
        res.value = v;
        if (!(m_nodata_en && v == m_nodata) && v != 0)
        begin
            zap = (c < rad) || (c + rad >= w) || (r < rad) || (r + rad >= h);
            for (int dy = -rad; dy <= rad && !zap; dy++)
            begin
                fr = (r + dy) % FLAG_ROWS;
                for (int dx = -rad; dx <= rad && !zap; dx++)
                begin
                    if (dx * dx + dy * dy <= rad * rad && bg_flags[fr*COLS_MAX + c + dx])
                    begin
                        zap = 1;
                    end
                end
            end
            if (zap)
            begin
                res.value = 0;
            end
        end
        res.last = (r + 1 == h) && (c + 1 == w);
        if (c + 1 >= w)
        begin
            out_col = 0;
            out_row = r + 1;
        end
        else
        begin
            out_col = c + 1;
        end
        return res;
    endfunction

    function automatic bit predict_filter(bit c, logic [31:0] v, output pix_result_t res);
        int unsigned rad, w, h, dly, n;
        logic [31:0] old;
        rad = radius_now();
        w = width_now();
        h = height_now();
        dly = rad * w + rad;
        if (c == CMD_FLUSH)
        begin
            if (in_row < h || out_row >= h)
            begin
                return 0;
            end
            n = out_row * w + out_col;
            res = erode_pixel(value_line[n % DELAY_DEPTH]);
            return 1;
        end
        if (in_row >= h)
        begin
            if (out_row < h)
            begin
                return 0;
            end
            restart_counts();
        end
        n = in_row * w + in_col;
        old = (n >= dly) ? value_line[(n - dly) % DELAY_DEPTH] : 0;
        value_line[n % DELAY_DEPTH] = v;
        bg_flags[(in_row % FLAG_ROWS)*COLS_MAX + in_col] = is_background(v);
        if (in_col + 1 >= w)
        begin
            in_col = 0;
            in_row++;
        end
        else
        begin
            in_col++;
        end
        if (n < dly)
        begin
            return 0;
        end
        res = erode_pixel(old);
        return 1;
    endfunction

    task automatic send_beat(bit c, logic [31:0] v, bit typed = 0,
                             logic [31:0] ev = 0, bit el = 0);
        bit acc;
        pix_result_t res;
        while (!calm && $urandom_range(0, 99) < 25)
        begin
            pin.valid <= 1'b0;
            @(posedge clk);
        end
        pin.valid <= 1'b1;
        pin.cmd <= c;
        pin.pixel_value <= v;
        acc = 0;
        while (!acc)
        begin
            @(negedge clk);
            acc = pin.ready;
            @(posedge clk);
        end
        items++;
        if (predict_filter(c, v, res))
        begin
            if (typed)
            begin
                res.value = ev;
                res.last = el;
            end
            pending_pixels.push_back(res);
        end
    endtask

    task automatic settle();
        pin.valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        apply_config(idx, d);
    endtask

    function automatic logic [31:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 5)
        begin
            return 0;
        end
        if (sel < 10)
        begin
            return m_nodata;
        end
        if (sel < 20)
        begin
            return $urandom;
        end
        return $urandom_range(1, 3);
    endfunction

    dir_row_t dir_rows[] = '{
        '{ROW_CFG, CFG_WIDTH, 0, 1, 0, 0, 0},
        '{ROW_CFG, CFG_HEIGHT, 0, 1, 0, 0, 0},
        '{ROW_PIX, 0, CMD_FLUSH, 0, 0, 0, 0},
        '{ROW_PIX, 0, CMD_PIXEL, 5, 0, 0, 0},
        '{ROW_PIX, 0, CMD_FLUSH, 0, 1, 0, 1},
        '{ROW_PIX, 0, CMD_FLUSH, 0, 0, 0, 0},
        '{ROW_PIX, 0, CMD_PIXEL, 7, 0, 0, 0},
        '{ROW_PIX, 0, CMD_PIXEL, 9, 0, 0, 0},
        '{ROW_PIX, 0, CMD_FLUSH, 0, 1, 0, 1},
        '{ROW_CFG, CFG_NODATA, 0, 32'h8000_0000, 0, 0, 0},
        '{ROW_CFG, CFG_NODATA_EN, 0, 1, 0, 0, 0},
        '{ROW_PIX, 0, CMD_PIXEL, 32'h8000_0000, 0, 0, 0},
        '{ROW_PIX, 0, CMD_FLUSH, 0, 1, 32'h8000_0000, 1},
        '{ROW_CFG, CFG_RADIUS, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_WIDTH, 0, 0, 0, 0, 0},
        '{ROW_CFG, CFG_HEIGHT, 0, 0, 0, 0, 0},
        '{ROW_PIX, 0, CMD_PIXEL, 32'h7FFF_FFFF, 0, 0, 0},
        '{ROW_CFG, CFG_UNUSED, 0, 32'hFFFF_FFFF, 0, 0, 0},
        '{ROW_PIX, 0, CMD_FLUSH, 0, 1, 0, 1},
        '{ROW_CFG, CFG_RADIUS, 0, 31, 0, 0, 0},
        '{ROW_CFG, CFG_WIDTH, 0, 2047, 0, 0, 0},
        '{ROW_CFG, CFG_HEIGHT, 0, 65535, 0, 0, 0},
        '{ROW_PIX, 0, CMD_PIXEL, 32'hFFFF_FFFF, 0, 0, 0},
        '{ROW_PIX, 0, CMD_PIXEL, 32'h0000_0000, 0, 0, 0},
        '{ROW_PIX, 0, CMD_FLUSH, 0, 0, 0, 0}
    };

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        pout.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                pout.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            else
            begin
                pout.ready <= calm || ($urandom_range(0, 99) >= 25);
                @(posedge clk);
            end
        end
    end

    initial
    begin
        pix_result_t want;
        forever
        begin
            @(negedge clk);
            if ((pin.valid && pin.ready) || (pout.valid && pout.ready))
            begin
                stall_count = 0;
            end
            else
            begin
                stall_count++;
            end
            if (pout.valid && pout.ready)
            begin
                if (pending_pixels.size() == 0)
                begin
                    $display("%0t: unexpected beat value %h last %b", $time,
                             pout.out_value, pout.frame_last);
                    errors++;
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (pout.out_value !== want.value)
                    begin
                        $display("%0t: out_value expected %h actual %h", $time,
                                 want.value, pout.out_value);
                        errors++;
                    end
                    if (pout.frame_last !== want.last)
                    begin
                        $display("%0t: frame_last expected %b actual %b", $time,
                                 want.last, pout.frame_last);
                        errors++;
                    end
                end
            end
            if (stall_count >= STALL_LIMIT)
            begin
                $display("%0t: no progress", $time);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned rad, w, h, frame_px, n_flush, phase;
        bit settled;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        pin.valid <= 1'b0;
        pin.cmd <= CMD_PIXEL;
        pin.pixel_value <= '0;
        m_radius = 1;
        m_width = 1024;
        m_height = 1;
        m_nodata = 0;
        m_nodata_en = 0;
        restart_counts();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        settled = 1;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                if (!settled)
                begin
                    settle();
                end
                settled = 1;
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                cfg_we <= 1'b0;
                settled = 0;
                send_beat(dir_rows[i].cmd, dir_rows[i].data, dir_rows[i].typed,
                          dir_rows[i].exp_value, dir_rows[i].exp_last);
            end
        end

        phase = 0;
        while (items < ITEM_GOAL)
        begin
            if (phase == 0 || phase == 5 || $urandom_range(0, 3) != 0)
            begin
                settle();
                if (phase == 5)
                begin
                    rad = 16;
                    w = 33;
                    h = $urandom_range(1, 2);
                end
                else
                begin
                    rad = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 5)
                                                      : $urandom_range(1, 3);
                    w = $urandom_range(1, 2 * rad + 6);
                    h = $urandom_range(1, 2 * rad + 6);
                    while (w * h > 150)
                    begin
                        h--;
                    end
                end
                write_reg(CFG_RADIUS, rad);
                write_reg(CFG_WIDTH, w);
                write_reg(CFG_HEIGHT, h);
                write_reg(CFG_NODATA, ($urandom_range(0, 1) != 0) ? $urandom
                                                                 : $urandom_range(1, 3));
                write_reg(CFG_NODATA_EN, $urandom_range(0, 1));
            end
            cfg_we <= 1'b0;
            calm = (phase == 3 || phase == 4);
            if (phase == 2)
            begin
                hold_req = 1;
            end
            rad = radius_now();
            w = width_now();
            h = height_now();
            frame_px = w * h;
            for (int k = 0; k < frame_px; k++)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    send_beat(CMD_FLUSH, $urandom);
                end
                send_beat(CMD_PIXEL, pick_value());
            end
            if ($urandom_range(0, 3) == 0)
            begin
                send_beat(CMD_PIXEL, $urandom);
            end
            n_flush = rad * w + rad;
            if (n_flush > frame_px)
            begin
                n_flush = frame_px;
            end
            n_flush += $urandom_range(0, 2);
            repeat (n_flush) send_beat(CMD_FLUSH, $urandom);
            phase++;
        end

        calm = 0;
        pin.valid <= 1'b0;
        while (pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            $display("%0t: %0d beats never arrived", $time, pending_pixels.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
